@@ sv/lcs_pkg.sv @@
package lcs_pkg;
  localparam int MAX_LEN   = 256;
  localparam int LEN_W     = $clog2(MAX_LEN + 1);
  localparam int ADDR_W    = $clog2(MAX_LEN);
  localparam int FR_DEPTH  = 2 * MAX_LEN + 1;
  localparam int FR_W      = $clog2(FR_DEPTH);
  localparam int DIAG_W    = LEN_W + 2;

  localparam logic [1:0] FUNC_LOAD_A   = 2'd0;
  localparam logic [1:0] FUNC_LOAD_B   = 2'd1;
  localparam logic [1:0] FUNC_COMPUTE  = 2'd2;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] char_value;
  } lcs_in_t;

  typedef struct packed {
    logic [8:0] lcs_length;
    logic       overflow;
  } lcs_out_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_START,     // seed frontier, set d=0, k=lo
    OP_READ,      // issue frontier reads for diagonal k
    OP_PICK,      // choose predecessor, form x
    OP_TXT,       // issue text reads at x,y
    OP_STEP,      // compare; advance snake
    OP_STORE,     // write frontier, move to next k / d
    OP_CLEAR      // clear lengths and flag
  } lcs_op_t;

  typedef struct packed {
    logic snake_ok;   // bounds ok and bytes match
    logic at_end;     // x>=m and y>=n
    logic last_k;     // k == hi
    logic empty;      // m==0 or n==0
  } lcs_stat_t;
endpackage

@@ sv/lcs_length_greedy_diff_top.sv @@
// LCS length engine (greedy diagonal search). Send func 0 / func 1 requests to append
// one byte to the first / second string (one per cycle while idle, no result; bytes
// past 256 are dropped and flagged). A func 2 request runs the search and returns one
// result with the LCS length and the overflow flag, then empties both strings. Compute
// runs a start step, then per diagonal a frontier read, a pick, a text read and a
// compare/store, with a text read and compare per matched byte, and a finish step;
// in_ready stays low from acceptance until the result is captured, also while a
// previous result still waits in the output register. func 3 is ignored.
module lcs_length_greedy_diff_top import lcs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  lcs_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output lcs_out_t out_data
);
  lcs_op_t   op;
  lcs_stat_t stat;
  logic      load_a, load_b, capture;
  logic [LEN_W-1:0] len_w;
  logic      ovf_w;
  logic      out_valid_r, out_valid_nxt;
  lcs_out_t  out_data_r;

  lcs_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .func(in_data.func), .stat, .op,
    .load_a, .load_b, .capture, .out_free(!out_valid_r || out_ready)
  );

  lcs_datapath u_dp (
    .clk, .rst_n, .load_a, .load_b, .char_value(in_data.char_value), .op, .stat,
    .len_out(len_w), .ovf_out(ovf_w)
  );

  // output register: holds a result until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (capture)   out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
    if (capture) begin
      out_data_r.lcs_length <= 9'(len_w);
      out_data_r.overflow   <= ovf_w;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
endmodule

@@ sv/lcs_datapath.sv @@
module lcs_datapath import lcs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load_a,
  input  logic              load_b,
  input  logic [7:0]        char_value,
  input  lcs_op_t           op,
  output lcs_stat_t         stat,
  output logic [LEN_W-1:0]  len_out,
  output logic              ovf_out
);
  logic [7:0] text_a [MAX_LEN];
  logic [7:0] text_b [MAX_LEN];
  logic [LEN_W-1:0] fx  [FR_DEPTH];
  logic [LEN_W-1:0] fl  [FR_DEPTH];

  logic [LEN_W-1:0] m_r, m_nxt, n_r, n_nxt;
  logic             drop_r, drop_nxt;
  logic signed [DIAG_W-1:0] d_r, d_nxt, k_r, k_nxt;
  logic signed [DIAG_W-1:0] lo_r, hi_r, lo_nxt, hi_nxt;
  logic [LEN_W-1:0] x_r, x_nxt, l_r, l_nxt;
  logic [LEN_W-1:0] xm_r, xp_r, lm_r, lp_r;
  logic [7:0]       ca_r, cb_r;

  logic signed [DIAG_W:0] y_s;
  logic signed [DIAG_W:0] ko_s;
  logic [FR_W-1:0]  ko, kom, kop;
  logic signed [DIAG_W-1:0] dn_lo, dn_hi, d_inc;

  // ko = k + n, always inside [0, 2*MAX_LEN]
  assign ko_s = (DIAG_W+1)'(k_r) + (DIAG_W+1)'($signed({1'b0, n_r}));
  assign ko   = FR_W'(ko_s);
  assign kom  = ko - FR_W'(1);
  assign kop  = ko + FR_W'(1);
  assign y_s  = (DIAG_W+1)'($signed({1'b0, x_r})) - (DIAG_W+1)'(k_r);

  function automatic logic signed [DIAG_W-1:0] smin(
    input logic signed [DIAG_W-1:0] a, input logic signed [DIAG_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  assign d_inc = d_r + DIAG_W'(1);
  assign dn_lo = -smin(d_inc, $signed({1'b0, n_r, 1'b0}) - d_inc);
  assign dn_hi =  smin(d_inc, $signed({1'b0, m_r, 1'b0}) - d_inc);

  always_comb begin
    stat.empty    = (m_r == '0) || (n_r == '0);
    stat.last_k   = (k_r == hi_r);
    stat.at_end   = (x_r >= m_r) && (y_s >= $signed({2'b0, n_r}));
    stat.snake_ok = (x_r < m_r) && (y_s >= 0) && (y_s < $signed({2'b0, n_r}))
                    && (ca_r == cb_r);
  end

  always_ff @(posedge clk) begin
    if (load_a && m_r < LEN_W'(MAX_LEN)) text_a[m_r[ADDR_W-1:0]] <= char_value;
    if (load_b && n_r < LEN_W'(MAX_LEN)) text_b[n_r[ADDR_W-1:0]] <= char_value;
    if (op == OP_TXT) begin
      ca_r <= text_a[x_r[ADDR_W-1:0]];
      cb_r <= text_b[y_s[ADDR_W-1:0]];
    end
    if (op == OP_START) begin
      fx[FR_W'(n_r) + FR_W'(1)] <= '0;
      fl[FR_W'(n_r) + FR_W'(1)] <= '0;
    end
    if (op == OP_READ) begin
      xm_r <= fx[kom]; lm_r <= fl[kom];
      xp_r <= fx[kop]; lp_r <= fl[kop];
    end
    if (op == OP_STORE) begin
      fx[ko] <= x_r;
      fl[ko] <= l_r;
    end
  end

  always_comb begin
    m_nxt = m_r; n_nxt = n_r; drop_nxt = drop_r;
    d_nxt = d_r; k_nxt = k_r; lo_nxt = lo_r; hi_nxt = hi_r;
    x_nxt = x_r; l_nxt = l_r;
    if (load_a) begin
      if (m_r < LEN_W'(MAX_LEN)) m_nxt = m_r + LEN_W'(1);
      else drop_nxt = 1'b1;
    end
    if (load_b) begin
      if (n_r < LEN_W'(MAX_LEN)) n_nxt = n_r + LEN_W'(1);
      else drop_nxt = 1'b1;
    end
    unique case (op)
      OP_START: begin
        d_nxt = '0; k_nxt = '0; lo_nxt = '0; hi_nxt = '0; l_nxt = '0;
      end
      OP_PICK: begin
        if (k_r == lo_r || (k_r != hi_r && xm_r < xp_r)) begin
          x_nxt = xp_r; l_nxt = lp_r;
        end else begin
          x_nxt = xm_r + LEN_W'(1); l_nxt = lm_r;
        end
      end
      OP_STEP: begin
        x_nxt = x_r + LEN_W'(1); l_nxt = l_r + LEN_W'(1);
      end
      OP_STORE: begin
        if (k_r == hi_r) begin
          d_nxt = d_inc; lo_nxt = dn_lo; hi_nxt = dn_hi; k_nxt = dn_lo;
        end else begin
          k_nxt = k_r + DIAG_W'(2);
        end
      end
      OP_CLEAR: begin
        m_nxt = '0; n_nxt = '0; drop_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_r <= '0; n_r <= '0; drop_r <= 1'b0;
    end else begin
      m_r <= m_nxt; n_r <= n_nxt; drop_r <= drop_nxt;
    end
    d_r <= d_nxt; k_r <= k_nxt; lo_r <= lo_nxt; hi_r <= hi_nxt;
    x_r <= x_nxt; l_r <= l_nxt;
  end

  assign len_out = stat.empty ? '0 : l_r;
  assign ovf_out = drop_r;
endmodule

@@ sv/lcs_ctrl.sv @@
module lcs_ctrl import lcs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic [1:0] func,
  input  lcs_stat_t stat,
  output lcs_op_t   op,
  output logic      load_a,
  output logic      load_b,
  output logic      capture,
  input  logic      out_free
);
  typedef enum logic [2:0] {
    S_IDLE, S_START, S_READ, S_PICK, S_TXT, S_STEP, S_DONE
  } state_t;
  state_t state_r, state_nxt;

  logic acc;
  assign in_ready = (state_r == S_IDLE);
  assign acc      = in_valid && in_ready;
  assign load_a   = acc && func == FUNC_LOAD_A;
  assign load_b   = acc && func == FUNC_LOAD_B;

  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    capture   = 1'b0;
    unique case (state_r)
      S_IDLE: if (acc && func == FUNC_COMPUTE) state_nxt = S_START;
      S_START: begin
        if (stat.empty) state_nxt = S_DONE;
        else begin op = OP_START; state_nxt = S_READ; end
      end
      S_READ: begin op = OP_READ; state_nxt = S_PICK; end
      S_PICK: begin op = OP_PICK; state_nxt = S_TXT; end
      S_TXT:  begin op = OP_TXT;  state_nxt = S_STEP; end
      S_STEP: begin
        if (stat.snake_ok) begin op = OP_STEP; state_nxt = S_TXT; end
        else if (stat.at_end) state_nxt = S_DONE;
        else begin op = OP_STORE; state_nxt = S_READ; end
      end
      S_DONE: begin
        if (out_free) begin
          capture = 1'b1; op = OP_CLEAR; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end
endmodule

@@ sv/lcs_checker.sv @@
module lcs_checker import lcs_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input lcs_in_t  in_data,
  input logic     out_valid,
  input logic     out_ready,
  input lcs_out_t out_data
);
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.lcs_length <= 9'(MAX_LEN)) else $error("lcs_length range");
  a_busy_after_compute: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.func == FUNC_COMPUTE |=> !in_ready)
    else $error("ready after compute");
  a_load_stays_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.func != FUNC_COMPUTE |=> in_ready)
    else $error("load stalled");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("out dropped");
endmodule

bind lcs_length_greedy_diff_top lcs_checker u_chk (.*);
